/* rtl/core/non_restoring_divider_core_assert.svh */
// Assertion macros shared by the divider's checker files.
// Depends on a clock named clk_i and an active-low reset named rst_ni in the scope of use.
`ifndef NON_RESTORING_DIVIDER_CORE_ASSERT_SVH
`define NON_RESTORING_DIVIDER_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define NRD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define NRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/nrd_pkg.sv */
// Shared types and constants for the non-restoring divider.
// Used by every module of the divider core and by its checker; no dependencies.
package nrd_pkg;

  // Operand width; the partial remainder carries one extra sign bit.
  localparam int unsigned Width = 16;
  localparam int unsigned CntW  = (Width > 2) ? $clog2(Width) : 1;
  // Cycles from an accepted transaction to the sampling edge of its result strobe.
  localparam int unsigned Latency = Width + 2;

  typedef struct packed {
    logic [Width-1:0] dividend;
    logic [Width-1:0] divisor;
  } nrd_in_t;

  typedef struct packed {
    logic [Width-1:0] quotient;
    logic [Width-1:0] remainder;
  } nrd_res_t;

  // Control handed to every cell of the remainder chain.
  typedef struct packed {
    logic load;   // clear the remainder bit and take the divisor bit
    logic en;     // write the adder output into the remainder bit
    logic shift;  // adder operand is the neighbor's bit (shift left)
    logic sub;    // subtract the divisor instead of adding it
  } cell_ctrl_t;

  // Everything the sequencer drives to the datapath.
  typedef struct packed {
    cell_ctrl_t chain;
    logic       q_shift;  // shift a new quotient bit in
    logic       capture;  // register the finished result
  } nrd_ctrl_t;

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StFix
  } nrd_state_e;

endpackage

/* rtl/core/nrd_cell.sv */
// One bit slice of the partial remainder: a remainder bit, a divisor bit and a full adder.
// Depends on nrd_pkg for the cell control struct.
module nrd_cell (
  input  logic                clk_i,
  input  nrd_pkg::cell_ctrl_t ctrl_i,
  input  logic                d_i,
  input  logic                shin_i,
  input  logic                cin_i,
  output logic                a_o,
  output logic                cout_o,
  output logic                res_o
);

  logic a_q, a_d;
  logic d_q;
  logic opa, opb, sum;

  // Operand select and full adder; subtraction adds the inverted divisor bit.
  always_comb begin
    opa    = ctrl_i.shift ? shin_i : a_q;
    opb    = ctrl_i.sub ? ~d_q : d_q;
    sum    = opa ^ opb ^ cin_i;
    cout_o = (opa & opb) | (opa & cin_i) | (opb & cin_i);
    res_o  = ctrl_i.en ? sum : a_q;
    a_d    = ctrl_i.load ? 1'b0 : res_o;
  end

  // Bit registers; the divisor bit is held for the whole transaction.
  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    if (ctrl_i.load) begin
      d_q <= d_i;
    end
  end

  assign a_o = a_q;

endmodule

/* rtl/core/nrd_ctrl.sv */
// Sequencer of the divider: counts the rounds and runs the final correction step.
// Depends on nrd_pkg for the state enum, the control struct and the width constants.
module nrd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              a_sign_i,
  output logic              busy_o,
  output nrd_pkg::nrd_ctrl_t ctrl_o
);

  nrd_pkg::nrd_state_e           state_q, state_d;
  logic [nrd_pkg::CntW-1:0]      cnt_q, cnt_d;
  localparam logic [nrd_pkg::CntW-1:0] LastRound = nrd_pkg::CntW'(nrd_pkg::Width - 1);

  // State and round counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nrd_pkg::StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state and control for the cell chain.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ctrl_o  = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      nrd_pkg::StIdle: begin
        busy_o = 1'b0;
        if (start_i) begin
          ctrl_o.chain.load = 1'b1;
          cnt_d             = '0;
          state_d           = nrd_pkg::StRun;
        end
      end
      nrd_pkg::StRun: begin
        // Shift, then subtract after a non-negative remainder or add after a negative one.
        ctrl_o.chain.en    = 1'b1;
        ctrl_o.chain.shift = 1'b1;
        ctrl_o.chain.sub   = ~a_sign_i;
        ctrl_o.q_shift     = 1'b1;
        cnt_d              = cnt_q + 1'b1;
        if (cnt_q == LastRound) begin
          state_d = nrd_pkg::StFix;
        end
      end
      nrd_pkg::StFix: begin
        // A negative remainder gets the divisor added back once.
        ctrl_o.chain.en = a_sign_i;
        ctrl_o.capture  = 1'b1;
        state_d         = nrd_pkg::StIdle;
      end
      default: begin
        state_d = nrd_pkg::StIdle;
      end
    endcase
  end

endmodule

/* rtl/core/non_restoring_divider_core.sv */
// Unsigned non-restoring divider built from a chain of remainder bit cells.
// Depends on nrd_pkg, nrd_ctrl and nrd_cell.
//
// Usage:
//   A transaction is accepted at a rising edge with start high and busy low; in_i
//   carries dividend and divisor. busy rises the cycle after and stays high through
//   the rounds, one quotient bit per cycle through the cell chain, and through the
//   correction step that adds the divisor back to a negative remainder.
//   The result appears on res_o with valid_o high for exactly one cycle, registered
//   from the correction step. The receiver cannot stall; the result register
//   is separate from the chain, so a new transaction can be accepted in the cycle
//   that shows the previous result. No transaction is accepted while busy, so
//   each one is finished before the next is taken.
//   A zero divisor gives an all-ones quotient and the dividend as remainder.
//   Reset returns the sequencer to idle and clears valid_o; no transaction is lost
//   other than one in flight.
module non_restoring_divider_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  nrd_pkg::nrd_in_t  in_i,
  output logic             valid_o,
  output nrd_pkg::nrd_res_t res_o
);

  localparam int unsigned W = nrd_pkg::Width;

  nrd_pkg::nrd_ctrl_t ctrl;
  logic [W:0]   a_bits;
  logic [W:0]   res_bits;
  logic [W:0]   carry;
  logic [W:0]   shin;
  logic [W-1:0] q_q;
  logic         valid_q;
  nrd_pkg::nrd_res_t res_q;

  // Sequencer.
  nrd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .a_sign_i (a_bits[W]),
    .busy_o   (busy),
    .ctrl_o   (ctrl)
  );

  // Carry enters at the low cell; the quotient's top bit shifts into it.
  assign carry[0] = ctrl.chain.sub;
  assign shin[0]  = q_q[W-1];

  // Remainder chain: each cell takes its lower neighbor's bit and carry.
  for (genvar i = 0; i <= W; i++) begin : g_cell
    logic d_bit;
    logic cout;
    if (i < W) begin : g_data
      assign d_bit = in_i.divisor[i];
      assign carry[i+1] = cout;
      assign shin[i+1]  = a_bits[i];
    end else begin : g_sign
      assign d_bit = 1'b0;
    end
    nrd_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl.chain),
      .d_i    (d_bit),
      .shin_i (shin[i]),
      .cin_i  (carry[i]),
      .a_o    (a_bits[i]),
      .cout_o (cout),
      .res_o  (res_bits[i])
    );
  end

  // Quotient register: loaded with the dividend, one bit shifted in per round.
  always_ff @(posedge clk_i) begin
    if (ctrl.chain.load) begin
      q_q <= in_i.dividend;
    end else if (ctrl.q_shift) begin
      q_q <= {q_q[W-2:0], ~res_bits[W]};
    end
  end

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctrl.capture;
    end
  end

  // Result payload, taken after the correction step.
  always_ff @(posedge clk_i) begin
    if (ctrl.capture) begin
      res_q.quotient  <= q_q;
      res_q.remainder <= res_bits[W-1:0];
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

/* rtl/core/nrd_checker.sv */
// Port-level checker for the divider core, bound to the top level.
// Depends on nrd_pkg and the assertion macros in non_restoring_divider_core_assert.svh.
`include "non_restoring_divider_core_assert.svh"

module nrd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input nrd_pkg::nrd_in_t  in_i,
  input logic              valid_o,
  input nrd_pkg::nrd_res_t res_o
);

  logic accept;
  assign accept = start && !busy;

  // An accepted transaction keeps the core busy in the following cycle.
  `NRD_ASSERT_NEXT(a_accept_busy, accept, busy, "core not busy after a transaction")

  // The result strobe lasts a single cycle.
  `NRD_ASSERT_NEXT(a_valid_pulse, valid_o, !valid_o, "result strobe longer than one cycle")

  // A result is shown only once the core has gone idle.
  `NRD_ASSERT_SAME(a_valid_idle, valid_o, !busy, "result shown while still busy")

  // Division by one returns the dividend after the fixed latency.
  `NRD_ASSERT_SAME(a_div_one, accept && (in_i.divisor == nrd_pkg::Width'(1)),
    ##(nrd_pkg::Latency) (valid_o && (res_o.quotient == $past(in_i.dividend, nrd_pkg::Latency))
    && (res_o.remainder == '0)), "division by one gave a wrong result")

endmodule

bind non_restoring_divider_core nrd_checker u_nrd_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .in_i    (in_i),
  .valid_o (valid_o),
  .res_o   (res_o)
);

/* test/non_restoring_divider_core_tb.sv */
// Self-checking testbench for non_restoring_divider_core: directed and random divisions
// checked against a local bit-level non-restoring model. Depends on nrd_pkg and the core.
`timescale 1ns / 1ps

module non_restoring_divider_core_tb;

  // Cycles without any accepted transaction or result before the run is declared hung.
  localparam int unsigned StallLimit = 40 * nrd_pkg::Latency;
  localparam int unsigned RandomPerPhase = 540;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  nrd_pkg::nrd_in_t  in_i;
  logic              valid_o;
  nrd_pkg::nrd_res_t res_o;

  non_restoring_divider_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .in_i   (in_i),
    .valid_o(valid_o),
    .res_o  (res_o)
  );

  // Keeps the quotient/remainder pairs still owed by the core, oldest first.
  class div_scoreboard;
    nrd_pkg::nrd_res_t owed_divisions[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned zero_divisors;

    function new();
      mismatches    = 0;
      checked       = 0;
      zero_divisors = 0;
    endfunction

    // Non-restoring division with a Width+1 bit partial remainder. The add or
    // subtract choice follows the sign held before the shift of each round.
    function nrd_pkg::nrd_res_t nonrestoring_divide(nrd_pkg::nrd_in_t op);
      logic [nrd_pkg::Width:0]   part;
      logic [nrd_pkg::Width-1:0] quo;
      logic                      was_neg;
      nrd_pkg::nrd_res_t         res;
      part = '0;
      quo  = op.dividend;
      for (int i = 0; i < nrd_pkg::Width; i++) begin
        was_neg = part[nrd_pkg::Width];
        part    = {part[nrd_pkg::Width-1:0], quo[nrd_pkg::Width-1]};
        quo     = {quo[nrd_pkg::Width-2:0], 1'b0};
        if (was_neg) begin
          part = part + {1'b0, op.divisor};
        end else begin
          part = part - {1'b0, op.divisor};
        end
        quo[0] = ~part[nrd_pkg::Width];
      end
      // A negative final remainder gets the divisor added back once.
      if (part[nrd_pkg::Width]) begin
        part = part + {1'b0, op.divisor};
      end
      res.quotient  = quo;
      res.remainder = part[nrd_pkg::Width-1:0];
      return res;
    endfunction

    function void note_operands(nrd_pkg::nrd_in_t op);
      if (op.divisor == '0) begin
        zero_divisors++;
      end
      owed_divisions.push_back(nonrestoring_divide(op));
    endfunction

    function void check_result(nrd_pkg::nrd_res_t got);
      nrd_pkg::nrd_res_t want;
      if (owed_divisions.size() == 0) begin
        $error("unexpected result: quotient %h, remainder %h", got.quotient, got.remainder);
        mismatches++;
        return;
      end
      want = owed_divisions.pop_front();
      checked++;
      if (got.quotient !== want.quotient) begin
        $error("quotient: expected %h, actual %h", want.quotient, got.quotient);
        mismatches++;
      end
      if (got.remainder !== want.remainder) begin
        $error("remainder: expected %h, actual %h", want.remainder, got.remainder);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return owed_divisions.size();
    endfunction
  endclass

  div_scoreboard sb;
  int unsigned   quiet_cycles;
  int unsigned   issued;

  // Free-running clock, 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Results are strobed for one cycle and cannot be held off.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      sb.check_result(res_o);
    end
  end

  // Watchdog on cycles where neither a transaction nor a result moves.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Presents one transaction, with random idle cycles ahead of it, and waits
  // until the core takes it. Returns at the accepting edge.
  task automatic send_division(nrd_pkg::nrd_in_t op, int unsigned idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      in_i  <= $urandom;
      @(posedge clk_i);
    end
    start <= 1'b1;
    in_i  <= op;
    do begin
      @(posedge clk_i);
    end while (busy);
    sb.note_operands(op);
    issued++;
  endtask

  task automatic send_pair(logic [nrd_pkg::Width-1:0] num, logic [nrd_pkg::Width-1:0] den);
    nrd_pkg::nrd_in_t op;
    op.dividend = num;
    op.divisor  = den;
    send_division(op, 0);
  endtask

  // Operand mix that favors the corners of the shift/add/subtract sequence.
  function automatic nrd_pkg::nrd_in_t random_operands();
    nrd_pkg::nrd_in_t op;
    op.dividend = nrd_pkg::Width'($urandom);
    op.divisor  = nrd_pkg::Width'($urandom);
    case ($urandom_range(0, 11))
      0: op.divisor = '0;
      1: op.divisor = nrd_pkg::Width'($urandom_range(1, 15));
      2: op.divisor = op.dividend - nrd_pkg::Width'($urandom_range(0, 3));
      3: op.divisor = op.dividend + nrd_pkg::Width'($urandom_range(0, 3));
      4: op.dividend = nrd_pkg::Width'($urandom_range(0, 255));
      5: op.divisor[nrd_pkg::Width-1] = 1'b1;
      6: op.dividend[nrd_pkg::Width-1] = 1'b1;
      7: op.divisor = op.divisor >> $urandom_range(0, nrd_pkg::Width - 1);
      default: ;
    endcase
    return op;
  endfunction

  initial begin
    int unsigned idle_setting [3];
    sb           = new();
    issued       = 0;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    in_i         = '0;
    idle_setting = '{0, 67, 13};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed cases: zero divisors, unit and full-scale operands, equal
    // operands, a divisor above the dividend and alternating bit patterns.
    send_pair(16'h0000, 16'h0000);
    send_pair(16'hFFFF, 16'h0000);
    send_pair(16'd12345, 16'h0000);
    send_pair(16'h0000, 16'h0001);
    send_pair(16'hFFFF, 16'h0001);
    send_pair(16'h0001, 16'h0001);
    send_pair(16'hFFFF, 16'hFFFF);
    send_pair(16'h0001, 16'hFFFF);
    send_pair(16'h0000, 16'hFFFF);
    send_pair(16'hFFFE, 16'hFFFF);
    send_pair(16'hFFFF, 16'hFFFE);
    send_pair(16'h8000, 16'h8000);
    send_pair(16'h7FFF, 16'h8000);
    send_pair(16'h8000, 16'h0003);
    send_pair(16'hFFFF, 16'h0002);
    send_pair(16'd100, 16'd7);
    send_pair(16'd7, 16'd100);
    send_pair(16'hAAAA, 16'h5555);
    send_pair(16'h5555, 16'hAAAA);
    send_pair(16'h1234, 16'h00FF);

    // Random divisions under each sender idling setting.
    foreach (idle_setting[p]) begin
      repeat (RandomPerPhase) begin
        send_division(random_operands(), idle_setting[p]);
      end
    end
    start <= 1'b0;

    // Drain, then give any stray strobe time to show up.
    while (sb.outstanding() != 0) begin
      @(posedge clk_i);
    end
    repeat (nrd_pkg::Latency + 4) @(posedge clk_i);

    if (sb.outstanding() != 0) begin
      $error("%0d divisions never returned a result", sb.outstanding());
      sb.mismatches++;
    end

    $display("Ran %0d divisions (%0d with a zero divisor) at sender idling of 0, 67 and 13 percent.",
             issued, sb.zero_divisors);
    $display("Compared %0d results; %0d discrepancies.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/nrd_pkg.sv
rtl/core/nrd_cell.sv
rtl/core/nrd_ctrl.sv
rtl/core/non_restoring_divider_core.sv
rtl/core/nrd_checker.sv
test/non_restoring_divider_core_tb.sv
